>>> rtl/tagf_pkg.sv
`timescale 1ns / 1ps

package tagf_pkg;

  // Field and word widths
  localparam int COORD_W = 32;
  localparam int N_COORD = 12;
  localparam int IN_W    = COORD_W * N_COORD;
  localparam int ENT_W   = 32;
  localparam int N_ENT   = 9;
  localparam int DETQ_W  = 64;
  localparam int OUT_W   = ENT_W * N_ENT + DETQ_W;
  localparam int STAT_W  = 2;

  // Internal exact widths
  localparam int EW   = 33;   // half edge, Q16.17
  localparam int PW   = 2 * EW;  // edge product
  localparam int CW   = PW + 1;  // cofactor, units 2^-34
  localparam int LOW_W = 34;     // low slice of cofactor for det partials
  localparam int PLW  = EW + LOW_W + 1;
  localparam int PHW  = EW + (CW - LOW_W);
  localparam int DW   = 100;  // determinant, units 2^-51
  localparam int ADW  = DW - 1;
  localparam int ACW  = CW - 1;
  localparam int NW   = 102;  // rounded numerator
  localparam int RW   = 101;  // remainder and doubled divisor
  localparam int QW   = 31;   // quotient bits below saturation
  localparam int NST  = QW + 10;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_NEG  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // Edge index: row*3 + col, rows x,y,z and cols r,s,t.
  // Cofactor i = e[PA[2i]]*e[PB[2i]] - e[PA[2i+1]]*e[PB[2i+1]]
  localparam logic [3:0] PA [0:17] = '{4'd4, 4'd7, 4'd7, 4'd1, 4'd1, 4'd4,
                                       4'd6, 4'd3, 4'd0, 4'd6, 4'd3, 4'd0,
                                       4'd3, 4'd6, 4'd6, 4'd0, 4'd0, 4'd3};
  localparam logic [3:0] PB [0:17] = '{4'd8, 4'd5, 4'd2, 4'd8, 4'd5, 4'd2,
                                       4'd5, 4'd8, 4'd8, 4'd2, 4'd2, 4'd5,
                                       4'd7, 4'd4, 4'd1, 4'd7, 4'd4, 4'd1};

  typedef struct packed {
    logic [N_ENT-1:0][RW-1:0] r;
    logic [N_ENT-1:0][QW-1:0] nl;
    logic [N_ENT-1:0][QW-1:0] q;
    logic [N_ENT-1:0]         neg;
    logic [N_ENT-1:0]         ovf;
    logic [RW-1:0]            d2;
    logic [DETQ_W-1:0]        det;
    status_t                  status;
  } div_t;

endpackage

>>> rtl/tetra_affine_geometric_factors_top.sv
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// s_axis   in   384    vertex1_x .. vertex4_z, 32 bits each, signed Q16.16
// m_axis   out  352+2  dr_dx .. dt_dz (Q16.16), determinant (Q48.16), tuser: status
//
// One element per cycle while the output is not stalled: edge, cofactor and
// determinant arithmetic, then a 31-stage restoring divider, one quotient bit
// per stage for all nine entries at once, then the output register.
// rst clears all valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module tetra_affine_geometric_factors_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // vertex1_x, vertex1_y, vertex1_z, vertex2_x .. vertex4_z
  input  logic [tagf_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // dr_dx, dr_dy, dr_dz, ds_dx, ds_dy, ds_dz, dt_dx, dt_dy, dt_dz, determinant
  output logic [tagf_pkg::OUT_W-1:0]     m_axis_tdata,
  // status
  output logic [tagf_pkg::STAT_W-1:0]    m_axis_tuser
);
  import tagf_pkg::*;

  logic                    en;
  logic [NST-1:0]          vld;

  logic signed [EW-1:0]    e1  [N_ENT];
  logic signed [PW-1:0]    pr2 [2*N_ENT];
  logic signed [EW-1:0]    r2  [3];
  logic signed [CW-1:0]    c3  [N_ENT];
  logic signed [EW-1:0]    r3  [3];
  logic signed [CW-1:0]    c4  [N_ENT];
  logic signed [PLW-1:0]   pl4 [3];
  logic signed [PHW-1:0]   ph4 [3];
  logic signed [CW-1:0]    c5  [N_ENT];
  logic signed [DW-1:0]    t5  [3];
  logic signed [CW-1:0]    c6  [N_ENT];
  logic signed [DW-1:0]    det6;
  logic [ACW-1:0]          ac7 [N_ENT];
  logic [N_ENT-1:0]        neg7;
  logic [ADW-1:0]          ad7;
  logic                    dneg7;
  logic                    zero7;
  logic [NW-1:0]           n8  [N_ENT];
  logic [N_ENT-1:0]        neg8;
  logic [RW-1:0]           d28;
  logic [DETQ_W-1:0]       detq8;
  status_t                 stat8;
  div_t                    dv      [0:QW];
  div_t                    dv_next [1:QW];
  logic [OUT_W-1:0]        out_data;
  status_t                 out_stat;

  // Advance everything together unless the output word is stuck
  assign en            = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // One divider step per stage: shift in a numerator bit, compare, subtract
  always_comb begin
    logic [RW-1:0] t;
    logic          ge;
    t  = '0;
    ge = 1'b0;
    for (int s = 0; s < QW; s++) begin
      dv_next[s+1] = dv[s];
      for (int i = 0; i < N_ENT; i++) begin
        t  = {dv[s].r[i][RW-2:0], dv[s].nl[i][QW-1]};
        ge = (t >= dv[s].d2);
        dv_next[s+1].r[i]  = ge ? t - dv[s].d2 : t;
        dv_next[s+1].nl[i] = {dv[s].nl[i][QW-2:0], 1'b0};
        dv_next[s+1].q[i]  = {dv[s].q[i][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Half edges from vertex 1
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          e1[k*3+j] <= EW'($signed(s_axis_tdata[((j+1)*3+k)*COORD_W +: COORD_W]))
                     - EW'($signed(s_axis_tdata[k*COORD_W +: COORD_W]));
        end
      end
      // Edge products
      for (int p = 0; p < 2*N_ENT; p++) begin
        pr2[p] <= PW'(e1[PA[p]]) * PW'(e1[PB[p]]);
      end
      r2[0] <= e1[0];
      r2[1] <= e1[3];
      r2[2] <= e1[6];
      // Cofactors
      for (int i = 0; i < N_ENT; i++) begin
        c3[i] <= CW'(pr2[2*i]) - CW'(pr2[2*i+1]);
      end
      r3 <= r2;
      // Determinant partial products, cofactor cut in two slices
      for (int j = 0; j < 3; j++) begin
        pl4[j] <= PLW'(r3[j]) * PLW'($signed({1'b0, c3[j][LOW_W-1:0]}));
        ph4[j] <= PHW'(r3[j]) * PHW'($signed(c3[j][CW-1:LOW_W]));
      end
      c4 <= c3;
      // Join slices
      for (int j = 0; j < 3; j++) begin
        t5[j] <= (DW'(ph4[j]) <<< LOW_W) + DW'(pl4[j]);
      end
      c5 <= c4;
      // Sum the three terms
      det6 <= t5[0] + t5[1] + t5[2];
      c6   <= c5;
      // Magnitudes and signs
      for (int i = 0; i < N_ENT; i++) begin
        ac7[i]  <= c6[i][CW-1] ? ACW'(-c6[i]) : ACW'(c6[i]);
        neg7[i] <= c6[i][CW-1] ^ det6[DW-1];
      end
      ad7   <= det6[DW-1] ? ADW'(-det6) : ADW'(det6);
      dneg7 <= det6[DW-1];
      zero7 <= (det6 == '0);
      // Rounded numerators, doubled divisor, rounded determinant
      for (int i = 0; i < N_ENT; i++) begin
        n8[i] <= (NW'(ac7[i]) << (LOW_W + 0)) + NW'(ad7);
      end
      neg8 <= neg7;
      d28  <= RW'({ad7, 1'b0});
      begin
        logic [DW-1:0]       sum;
        logic [DW-36:0]      m;
        sum = DW'(ad7) + (DW'(1) << 34);
        m   = sum[DW-1:35];
        if (dneg7) begin
          detq8 <= (m[DW-36:63] != '0) ? {1'b1, {(DETQ_W-1){1'b0}}}
                                        : DETQ_W'(-m[DETQ_W-1:0]);
        end else begin
          detq8 <= (m[DW-36:63] != '0) ? {1'b0, {(DETQ_W-1){1'b1}}} : m[DETQ_W-1:0];
        end
      end
      stat8 <= zero7 ? ST_ZERO : (dneg7 ? ST_NEG : ST_OK);
      // Load divider: top bits of numerator, saturation test
      for (int i = 0; i < N_ENT; i++) begin
        dv[0].r[i]   <= RW'(n8[i][NW-1:QW]);
        dv[0].nl[i]  <= n8[i][QW-1:0];
        dv[0].q[i]   <= '0;
        dv[0].ovf[i] <= (RW'(n8[i][NW-1:QW]) >= d28);
      end
      dv[0].neg    <= neg8;
      dv[0].d2     <= d28;
      dv[0].det    <= detq8;
      dv[0].status <= stat8;
      for (int s = 1; s <= QW; s++) begin
        dv[s] <= dv_next[s];
      end
      // Sign, saturate, force zero on a singular element
      for (int i = 0; i < N_ENT; i++) begin
        if (dv[QW].status == ST_ZERO) begin
          out_data[i*ENT_W +: ENT_W] <= '0;
        end else if (dv[QW].ovf[i]) begin
          out_data[i*ENT_W +: ENT_W] <= dv[QW].neg[i] ? {1'b1, {(ENT_W-1){1'b0}}}
                                                       : {1'b0, {(ENT_W-1){1'b1}}};
        end else begin
          out_data[i*ENT_W +: ENT_W] <= dv[QW].neg[i] ? ENT_W'(-{1'b0, dv[QW].q[i]})
                                                       : {1'b0, dv[QW].q[i]};
        end
      end
      out_data[N_ENT*ENT_W +: DETQ_W] <= (dv[QW].status == ST_ZERO) ? '0 : dv[QW].det;
      out_stat <= dv[QW].status;
    end
  end

  // A singular element carries an all-zero word
  a_zero_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_ZERO) |-> (m_axis_tdata == '0))
    else $error("zero determinant with nonzero word");

  // Negative status never pairs with a positive determinant field
  a_neg_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_NEG)
      |-> m_axis_tdata[OUT_W-1] || (m_axis_tdata[OUT_W-1 -: DETQ_W] == '0))
    else $error("negative status with positive determinant");

  // Ok status never pairs with a negative determinant field
  a_ok_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_OK) |-> !m_axis_tdata[OUT_W-1])
    else $error("ok status with negative determinant");

endmodule

>>> dv/tagf_checker.sv
`timescale 1ns / 1ps

module tagf_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [tagf_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tagf_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic [tagf_pkg::STAT_W-1:0]   m_axis_tuser,
  output int                            outstanding,
  output int                            errors
);
  import tagf_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [N_ENT-1:0][ENT_W-1:0] inv;
    logic [DETQ_W-1:0]           det;
    status_t                     status;
  } factors_t;

  factors_t pending_factors[$];

  // Cofactor over determinant, scaled to Q16.16, rounded half away, clamped
  function automatic logic [ENT_W-1:0] inverse_entry(input wide_t cof, input wide_t det);
    wide_t num;
    logic [127:0] an, ad, q;
    logic neg;
    num = cof <<< 33;
    neg = num[127] != det[127];
    an = num[127] ? -num : num;
    ad = det[127] ? -det : det;
    q = ((an << 1) + ad) / (ad << 1);
    if (neg) begin
      if (q >= 128'h8000_0000) return 32'h8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7fff_ffff) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  // Work out the Jacobian inverse and determinant for one element
  function automatic factors_t element_factors(input logic [IN_W-1:0] d);
    wide_t e[3][3];
    wide_t c[9];
    wide_t det, a, b;
    logic [127:0] m;
    factors_t f;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        a = $signed(d[k*COORD_W +: COORD_W]);
        b = $signed(d[((j+1)*3+k)*COORD_W +: COORD_W]);
        e[k][j] = b - a;
      end
    end
    c[0] = e[1][1]*e[2][2] - e[2][1]*e[1][2];
    c[1] = e[2][1]*e[0][2] - e[0][1]*e[2][2];
    c[2] = e[0][1]*e[1][2] - e[1][1]*e[0][2];
    c[3] = e[2][0]*e[1][2] - e[1][0]*e[2][2];
    c[4] = e[0][0]*e[2][2] - e[2][0]*e[0][2];
    c[5] = e[1][0]*e[0][2] - e[0][0]*e[1][2];
    c[6] = e[1][0]*e[2][1] - e[2][0]*e[1][1];
    c[7] = e[2][0]*e[0][1] - e[0][0]*e[2][1];
    c[8] = e[0][0]*e[1][1] - e[1][0]*e[0][1];
    det = e[0][0]*c[0] + e[1][0]*c[1] + e[2][0]*c[2];
    f = '0;
    if (det == 0) begin
      f.status = ST_ZERO;
      return f;
    end
    for (int j = 0; j < N_ENT; j++) f.inv[j] = inverse_entry(c[j], det);
    m = ((det[127] ? -det : det) + (128'd1 << 34)) >> 35;
    if (det[127]) begin
      f.status = ST_NEG;
      f.det = (m >= (128'd1 << 63)) ? 64'h8000_0000_0000_0000 : -m[63:0];
    end else begin
      f.status = ST_OK;
      f.det = (m > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : m[63:0];
    end
    return f;
  endfunction

  // Report a field mismatch, only the first few in full
  task automatic flag_field(input int idx, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch field %0d: expected %h, got %h", idx, want, got);
  endtask

  // Queue predictions on input words, compare on output words
  always @(posedge clk) begin
    factors_t want, got;
    if (rst) begin
      pending_factors.delete();
      outstanding <= 0;
      errors = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_factors.push_back(element_factors(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.inv = m_axis_tdata[N_ENT*ENT_W-1:0];
        got.det = m_axis_tdata[N_ENT*ENT_W +: DETQ_W];
        got.status = status_t'(m_axis_tuser);
        if (pending_factors.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output word %h", m_axis_tdata);
        end else begin
          want = pending_factors.pop_front();
          for (int j = 0; j < N_ENT; j++)
            if (got.inv[j] !== want.inv[j]) flag_field(j, want.inv[j], got.inv[j]);
          if (got.det !== want.det) flag_field(9, want.det, got.det);
          if (got.status !== want.status) flag_field(10, want.status, got.status);
        end
      end
      outstanding <= pending_factors.size();
    end
  end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tagf_pkg::*;

  localparam int N_RANDOM   = 1430;
  localparam int STALL_LIMIT = 5000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [STAT_W-1:0]    m_axis_tuser;
  int                   outstanding;
  int                   errors;
  int                   sent = 0;
  int                   received = 0;
  int                   rx_gap = 0;
  int                   rx_hold = 0;
  bit                   hold_done = 0;
  int                   idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tetra_affine_geometric_factors_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  tagf_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .outstanding(outstanding), .errors(errors)
  );

  // Receiver: random gaps, no-gap stretches, one long hold once 300 words are received
  always @(posedge clk) begin
    int w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!hold_done && received >= 300) begin
      m_axis_tready <= 1'b0;
      rx_hold <= 200;
      hold_done <= 1;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (m_axis_tready && m_axis_tvalid) begin
      received <= received + 1;
      w = ((received / 150) % 3 == 1) ? 0 : $urandom_range(0, 4);
      m_axis_tready <= (w == 0);
      rx_gap <= (w == 0) ? 0 : w - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one element, after a random gap outside the no-gap stretches
  task automatic send_element(input logic [IN_W-1:0] d);
    int w;
    w = ((sent / 200) % 3 == 2) ? 0 : $urandom_range(0, 4);
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Build an element from the first vertex and the edge vectors to the other vertices
  function automatic logic [IN_W-1:0] make_element(input logic [2:0][2:0][31:0] edges,
                                                   input logic [2:0][31:0] v1);
    logic [IN_W-1:0] d;
    for (int k = 0; k < 3; k++) begin
      d[k*32 +: 32] = v1[k];
      for (int j = 0; j < 3; j++) d[((j+1)*3+k)*32 +: 32] = v1[k] + edges[j][k];
    end
    return d;
  endfunction

  function automatic logic [31:0] rand_span(input int bits);
    logic [31:0] r;
    r = $urandom;
    return $signed(r) >>> (32 - bits);
  endfunction

  initial begin
    logic [IN_W-1:0] d;
    logic [2:0][2:0][31:0] ed;
    logic [2:0][31:0] v1;
    int kind, bits;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: degenerate, unit, mirrored, extremes, tiny and huge determinants
    send_element('0);
    ed = '0; ed[0][0] = 32'h1_0000; ed[1][1] = 32'h1_0000; ed[2][2] = 32'h1_0000;
    send_element(make_element(ed, '0));
    ed[2][2] = 32'hffff_0000;
    send_element(make_element(ed, '0));
    ed[0][0] = 32'h2; ed[1][1] = 32'h2; ed[2][2] = 32'h2;
    send_element(make_element(ed, '0));
    ed[0][0] = 32'h1; ed[1][1] = 32'h1; ed[2][2] = 32'hffff_ffff;
    send_element(make_element(ed, 96'h1234_5678_9abc_def0_0fed_cba9));
    ed[0][0] = 32'h7fff_0000; ed[1][1] = 32'h1; ed[2][2] = 32'h1;
    send_element(make_element(ed, '0));
    for (int i = 0; i < 12; i++) d[i*32 +: 32] = (i % 4 == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_element(d);
    for (int i = 0; i < 12; i++) d[i*32 +: 32] = (i % 3 == i / 3 % 3) ? 32'h7fff_ffff
                                                                      : 32'h8000_0000;
    send_element(d);
    send_element({12{32'h8000_0000}});
    send_element({12{32'hffff_ffff}});
    send_element({6{64'h5555_5555_aaaa_aaaa}});
    send_element({6{64'haaaa_aaaa_5555_5555}});
    send_element({{3{32'h7fff_ffff}}, {9{32'h8000_0000}}});
    ed = '0; ed[0] = {32'h3_0000, 32'h2_0000, 32'h1_0000};
    ed[1] = {32'h6_0000, 32'h4_0000, 32'h2_0000}; ed[2] = {32'h0, 32'h0, 32'h5_0000};
    send_element(make_element(ed, '0));
    ed[2] = '0;
    send_element(make_element(ed, 96'h1));
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 12; j++) d[j*32 +: 32] = $urandom;
      send_element(d);
    end

    // Random: mostly small well-shaped elements, some full range and degenerate
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (n == 700) begin
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
      end
      if (kind < 3) begin
        for (int j = 0; j < 12; j++) d[j*32 +: 32] = $urandom;
      end else begin
        bits = (kind == 9) ? $urandom_range(1, 6) : $urandom_range(8, 26);
        for (int k = 0; k < 3; k++) v1[k] = $urandom;
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) ed[j][k] = rand_span(bits);
        if (kind == 8) ed[2] = ($urandom_range(0, 1)) ? ed[0] : ed[0] + ed[1];
        d = make_element(ed, v1);
      end
      send_element(d);
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
